FILE: design/u32_to_decimal_ascii_defines.svh
`ifndef U32_TO_DECIMAL_ASCII_DEFINES_SVH
`define U32_TO_DECIMAL_ASCII_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define UDA_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("check failed in same cycle");

// check a condition in the cycle after its trigger
`define UDA_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("check failed in next cycle");

`endif

FILE: design/ud_pkg.sv
`default_nettype none

package ud_pkg;

   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int CHAR_W     = 6;
   localparam int BIT_CNT_W  = $clog2(VALUE_W);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

   localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_W - 1);
   localparam logic [DIG_CNT_W-1:0] LAST_DIGIT = DIG_CNT_W'(NUM_DIGITS - 1);

   localparam logic [CHAR_W-1:0] DIGIT_BASE_CODE = 6'd48;
   localparam logic [CHAR_W-1:0] SPACE_CODE      = 6'd32;

   localparam logic [DIGIT_W-1:0] ADJUST_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] ADJUST_ADD   = 4'd3;

   typedef logic [BCD_W-1:0] bcd_type;

   typedef struct packed {
      logic    valid;
      bcd_type bcd;
   } bcd_xfer_type;

endpackage

`default_nettype wire

FILE: design/ud_dabble.sv
`default_nettype none

`include "u32_to_decimal_ascii_defines.svh"

module ud_dabble
   import ud_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire logic [VALUE_W-1:0]  value,
   output bcd_xfer_type             xfer,
   output logic                     busy
);

   logic [VALUE_W-1:0]   bin_ff, bin_in;
   bcd_type              bcd_ff, bcd_in;
   bcd_type              bcd_adj;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 active_ff, active_in;
   logic                 done_ff, done_in;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= ADJUST_LIMIT) begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + ADJUST_ADD;
         end else begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (load) begin
         bin_in    = value;
         bcd_in    = '0;
         cnt_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_BIT) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign xfer.valid = done_ff;
   assign xfer.bcd   = bcd_ff;
   assign busy       = active_ff | done_ff;

   `UDA_ASSERT_NEXT(a_load_starts, load, active_ff)
   `UDA_ASSERT_NEXT(a_last_bit_done, active_ff && !load && cnt_ff == LAST_BIT, done_ff)
   `UDA_ASSERT_NOW(a_done_idle, done_ff, !active_ff)

endmodule

`default_nettype wire

FILE: design/ud_emit.sv
`default_nettype none

`include "u32_to_decimal_ascii_defines.svh"

module ud_emit
   import ud_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire bcd_xfer_type   xfer,
   output logic                busy,
   output logic                rsp_strobe,
   output logic [CHAR_W-1:0]   rsp_character,
   output logic                rsp_last
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIGITS = 2'd1;
   localparam logic [1:0] ST_SPACE  = 2'd2;

   logic [1:0]           state_ff, state_in;
   bcd_type              dig_ff, dig_in;
   logic [DIG_CNT_W-1:0] idx_ff, idx_in;
   logic                 seen_ff, seen_in;
   logic                 strobe_ff, strobe_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 last_ff, last_in;
   logic [DIGIT_W-1:0]   top_digit;

   assign top_digit = dig_ff[BCD_W-1 -: DIGIT_W];

   always_comb begin
      state_in  = state_ff;
      dig_in    = dig_ff;
      idx_in    = idx_ff;
      seen_in   = seen_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (xfer.valid) begin
               dig_in   = xfer.bcd;
               idx_in   = '0;
               seen_in  = 1'b0;
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            // drop leading zeros, but always print the units digit
            if (seen_ff || top_digit != '0 || idx_ff == LAST_DIGIT) begin
               strobe_in = 1'b1;
               char_in   = DIGIT_BASE_CODE + CHAR_W'(top_digit);
               seen_in   = 1'b1;
            end
            dig_in = {dig_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_DIGIT) begin
               state_in = ST_SPACE;
            end
         end
         ST_SPACE: begin
            strobe_in = 1'b1;
            char_in   = SPACE_CODE;
            last_in   = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dig_ff  <= dig_in;
      idx_ff  <= idx_in;
      seen_ff <= seen_in;
      char_ff <= char_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
   end

   assign busy          = state_ff != ST_IDLE;
   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   `UDA_ASSERT_NOW(a_last_is_space, last_ff, strobe_ff && char_ff == SPACE_CODE)
   `UDA_ASSERT_NEXT(a_space_ends, state_ff == ST_SPACE, strobe_ff && last_ff)
   `UDA_ASSERT_NOW(a_xfer_when_idle, xfer.valid, state_ff == ST_IDLE)

endmodule

`default_nettype wire

FILE: design/u32_to_decimal_ascii.sv
// Once start is taken, the bit-serial binary to BCD converter runs its 32 shift steps, hands
// the BCD digits to the emitter, which spends ten digit slots and then the space slot; each
// character leaves via an output register. No new value is taken until the emitter is idle.
// Each value yields 2 to 11 characters; the receiver cannot stall, busy guards the input.
// Reset is synchronous and active high; it clears the control state and drops any transaction.
`default_nettype none

module u32_to_decimal_ascii
   import ud_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [VALUE_W-1:0]  req_value,
   output logic                     rsp_strobe,
   output logic [CHAR_W-1:0]        rsp_character,
   output logic                     rsp_last
);

   bcd_xfer_type xfer;
   logic         conv_busy;
   logic         emit_busy;
   logic         load;

   assign load = start & ~busy;
   assign busy = conv_busy | emit_busy;

   ud_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .value (req_value),
      .xfer  (xfer),
      .busy  (conv_busy)
   );

   ud_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .xfer          (xfer),
      .busy          (emit_busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

FILE: dv/u32_to_decimal_ascii_tb.sv
module u32_to_decimal_ascii_tb;
   import ud_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } ascii_char_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [CHAR_W-1:0]  rsp_character;
   logic               rsp_last;

   ascii_char_type expected_chars[$];
   int             error_count = 0;
   int             sender_idle_pct = 0;

   u32_to_decimal_ascii uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic void push_decimal_chars(input logic [VALUE_W-1:0] value);
      logic [DIGIT_W-1:0] digits [NUM_DIGITS];
      logic [VALUE_W-1:0] rest;
      ascii_char_type     entry;
      int                 count;
      rest  = value;
      count = 0;
      do begin
         digits[count] = DIGIT_W'(rest % 10);
         rest = rest / 10;
         count++;
      end while (rest != 0 && count < NUM_DIGITS);
      for (int i = count - 1; i >= 0; i--) begin
         entry.code = DIGIT_BASE_CODE + CHAR_W'(digits[i]);
         entry.last = 1'b0;
         expected_chars.push_back(entry);
      end
      entry.code = SPACE_CODE;
      entry.last = 1'b1;
      expected_chars.push_back(entry);
   endfunction

   task automatic send_value(input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      push_decimal_chars(value);
   endtask

   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset && rsp_strobe) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected transaction, character %0d last %0b",
                     $time, rsp_character, rsp_last);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_character !== want.code) begin
               $display("%0t: character mismatch, expected %0d actual %0d",
                        $time, want.code, rsp_character);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last mismatch, expected %0b actual %0b",
                        $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   task automatic test_zero_and_extremes();
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'hFFFF_FFFE);
      send_value(32'h8000_0000);
   endtask

   task automatic test_digit_count_boundaries();
      logic [VALUE_W-1:0] power;
      power = 32'd10;
      for (int k = 1; k < NUM_DIGITS; k++) begin
         send_value(power - 1);
         send_value(power);
         power = power * 10;
      end
   endtask

   task automatic test_random_values(input int count, input int idle_pct);
      int shift;
      sender_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         shift = ($urandom_range(3) == 0) ? 0 : $urandom_range(31);
         send_value($urandom >> shift);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 8;
      test_zero_and_extremes();
      test_digit_count_boundaries();
      test_random_values(70, 8);
      test_random_values(70, 58);
      test_random_values(70, 0);
      start <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout", $time);
      $display("FAIL");
      $finish;
   end

endmodule
